// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the convolution RTL (flc_window).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/flc_pkg.sv -----
// ----------------------------------------------------------------------------
// flc_pkg
// Types, constants and helpers shared by the convolution block.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int MAX_TAPS   = 7;
    localparam int DLY_DEPTH  = MAX_TAPS - 1;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int OUT_W      = 34;
    localparam int TAPS_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TAPS_W-1:0] RST_TAPS  = TAPS_W'(1);
    localparam logic [COEF_W-1:0] RST_COEF0 = COEF_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT = 3'd0,
        CFG_COEF_0    = 3'd1,
        CFG_COEF_1    = 3'd2,
        CFG_COEF_2    = 3'd3,
        CFG_COEF_3    = 3'd4,
        CFG_COEF_4    = 3'd5,
        CFG_COEF_5    = 3'd6,
        CFG_COEF_6    = 3'd7
    } t_cfg_idx;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // Active configuration: tap count already clamped to 1..MAX_TAPS.
    typedef struct packed {
        logic [TAPS_W-1:0]       taps;
        t_coef [MAX_TAPS-1:0]    coef;
    } t_cfg;

    // One window beat: newest sample at index 0.
    typedef struct packed {
        t_sample [MAX_TAPS-1:0]  win;
        logic                    last;
    } t_win_beat;

    function automatic logic [TAPS_W-1:0] taps_eff(input logic [TAPS_W-1:0] raw);
        logic [TAPS_W-1:0] t;
        t = raw;
        if (raw == '0) begin
            t = TAPS_W'(1);
        end else if (raw > TAPS_W'(MAX_TAPS)) begin
            t = TAPS_W'(MAX_TAPS);
        end
        return t;
    endfunction

endpackage

// ----- hw/rtl/flc_if.sv -----
// ----------------------------------------------------------------------------
// flc interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface flc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [flc_pkg::SAMPLE_W-1:0]  sample;
    logic                                 last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface flc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [flc_pkg::OUT_W-1:0]     out_value;
    logic                                 out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

interface flc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [flc_pkg::CFG_IDX_W-1:0]        index;
    logic [flc_pkg::CFG_DATA_W-1:0]       wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/flc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// flc_cfg_regs
// Tap count and coefficient registers, written through the config channel.
// ----------------------------------------------------------------------------
module flc_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    flc_cfg_if.sink          i_cfg,
    output flc_pkg::t_cfg    o_cfg
);

    logic [flc_pkg::TAPS_W-1:0]                r_tap_count, n_tap_count;
    flc_pkg::t_coef [flc_pkg::MAX_TAPS-1:0]    r_coef, n_coef;
    logic [flc_pkg::COEF_W-1:0]                wd;

    assign i_cfg.ready = 1'b1;
    assign wd          = i_cfg.wdata[flc_pkg::COEF_W-1:0];

    always_comb begin
        n_tap_count = r_tap_count;
        n_coef      = r_coef;
        if (i_cfg.valid) begin
            case (flc_pkg::t_cfg_idx'(i_cfg.index))
                flc_pkg::CFG_TAP_COUNT: n_tap_count = i_cfg.wdata[flc_pkg::TAPS_W-1:0];
                flc_pkg::CFG_COEF_0:    n_coef[0]   = wd;
                flc_pkg::CFG_COEF_1:    n_coef[1]   = wd;
                flc_pkg::CFG_COEF_2:    n_coef[2]   = wd;
                flc_pkg::CFG_COEF_3:    n_coef[3]   = wd;
                flc_pkg::CFG_COEF_4:    n_coef[4]   = wd;
                flc_pkg::CFG_COEF_5:    n_coef[5]   = wd;
                flc_pkg::CFG_COEF_6:    n_coef[6]   = wd;
                default:                n_tap_count = r_tap_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= flc_pkg::RST_TAPS;
            // coef_0 in the low slice, all other taps zero
            r_coef      <= {{((flc_pkg::MAX_TAPS - 1) * flc_pkg::COEF_W){1'b0}},
                            flc_pkg::RST_COEF0};
        end else begin
            r_tap_count <= n_tap_count;
            r_coef      <= n_coef;
        end
    end

    assign o_cfg.taps = flc_pkg::taps_eff(r_tap_count);
    assign o_cfg.coef = r_coef;

endmodule

// ----- hw/rtl/flc_window.sv -----
// ----------------------------------------------------------------------------
// flc_window
// Delay line, window register and end-of-sequence flush sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flc_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    flc_in_if.sink                        i_in,
    input  logic [flc_pkg::TAPS_W-1:0]    i_taps,
    output flc_pkg::t_win_beat            o_win,
    output logic                          o_win_valid,
    input  logic                          i_win_ready
);

    flc_pkg::t_sample [flc_pkg::DLY_DEPTH-1:0]  r_dly, n_dly;
    flc_pkg::t_win_beat                         r_win, n_win;
    logic                                       r_win_vld, n_win_vld;
    logic [flc_pkg::TAPS_W-1:0]                 r_fl_rem, n_fl_rem;
    logic                                       win_en;
    logic                                       in_acc;

    assign win_en     = !r_win_vld || i_win_ready;
    assign i_in.ready = win_en && (r_fl_rem == '0);
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        n_dly     = r_dly;
        n_win     = r_win;
        n_win_vld = r_win_vld;
        n_fl_rem  = r_fl_rem;
        if (win_en) begin
            n_win_vld = 1'b0;
            if (r_fl_rem != '0) begin
                // flush: shift a zero sample into the window
                n_win.win[0] = '0;
                for (int k = 1; k < flc_pkg::MAX_TAPS; k++) begin
                    n_win.win[k] = r_win.win[k-1];
                end
                n_win.last = (r_fl_rem == flc_pkg::TAPS_W'(1));
                n_fl_rem   = r_fl_rem - flc_pkg::TAPS_W'(1);
                n_win_vld  = 1'b1;
            end else if (i_in.valid) begin
                n_win.win[0] = i_in.sample;
                for (int k = 1; k < flc_pkg::MAX_TAPS; k++) begin
                    n_win.win[k] = r_dly[k-1];
                end
                n_win.last = i_in.last_sample && (i_taps == flc_pkg::TAPS_W'(1));
                n_win_vld  = 1'b1;
                if (i_in.last_sample) begin
                    n_dly    = '0;
                    n_fl_rem = i_taps - flc_pkg::TAPS_W'(1);
                end else begin
                    n_dly[0] = i_in.sample;
                    for (int k = 1; k < flc_pkg::DLY_DEPTH; k++) begin
                        n_dly[k] = r_dly[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly     <= '0;
            r_win_vld <= 1'b0;
            r_fl_rem  <= '0;
        end else begin
            r_dly     <= n_dly;
            r_win_vld <= n_win_vld;
            r_fl_rem  <= n_fl_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_win       = r_win;
    assign o_win_valid = r_win_vld;

    `FLC_ASSERT_IMP(a_no_accept_in_flush, i_clk, i_rst_n, r_fl_rem != '0, !i_in.ready, "sample taken during flush")
    `FLC_ASSERT_IMP(a_flush_bound, i_clk, i_rst_n, 1'b1, r_fl_rem <= flc_pkg::TAPS_W'(flc_pkg::DLY_DEPTH), "flush count out of range")
    `FLC_ASSERT_NXT(a_dly_cleared, i_clk, i_rst_n, in_acc && i_in.last_sample, r_dly == '0, "delay line not cleared after last")

endmodule

// ----- hw/rtl/flc_mac.sv -----
// ----------------------------------------------------------------------------
// flc_mac
// Registered tap products, then the exact sum into the result register.
// ----------------------------------------------------------------------------
module flc_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  flc_pkg::t_win_beat    i_win,
    input  logic                  i_win_valid,
    output logic                  o_win_ready,
    input  flc_pkg::t_cfg         i_cfg,
    flc_out_if.source             o_out
);

    logic signed [flc_pkg::PROD_W-1:0]  r_prod [flc_pkg::MAX_TAPS];
    logic signed [flc_pkg::PROD_W-1:0]  n_prod [flc_pkg::MAX_TAPS];
    logic                               r_p_last, r_p_vld;
    logic signed [flc_pkg::OUT_W-1:0]   r_out_value, n_sum;
    logic                               r_out_last, r_o_vld;
    logic                               o_en, p_en;

    assign o_en        = !r_o_vld || o_out.ready;
    assign p_en        = !r_p_vld || o_en;
    assign o_win_ready = p_en;

    // taps beyond the active count weigh zero
    always_comb begin
        for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
            if (flc_pkg::TAPS_W'(k) < i_cfg.taps) begin
                n_prod[k] = flc_pkg::PROD_W'($signed(i_win.win[k]) * $signed(i_cfg.coef[k]));
            end else begin
                n_prod[k] = '0;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
            n_sum = n_sum + flc_pkg::OUT_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (p_en) begin
                r_p_vld <= i_win_valid;
            end
            if (o_en) begin
                r_o_vld <= r_p_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_en) begin
            r_prod   <= n_prod;
            r_p_last <= i_win.last;
        end
        if (o_en) begin
            r_out_value <= n_sum;
            r_out_last  <= r_p_last;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.out_value = r_out_value;
    assign o_out.out_last  = r_out_last;

endmodule

// ----- hw/rtl/full_linear_convolution.sv -----
// ----------------------------------------------------------------------------
// full_linear_convolution
// Streaming full linear convolution of a signed sample sequence with a
// kernel of up to seven taps, including the zero-padded tail on the last
// sample.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                         Beat taken when
//  --------  ---  ------------------------------  ------------------------
//  i_in      in   sample[15:0], last_sample       i_in.valid & i_in.ready
//  o_out     out  out_value[33:0], out_last       o_out.valid & o_out.ready
//  i_cfg     in   index[2:0], wdata[15:0]         i_cfg.valid (always ready)
//
//  One sample beat per cycle while i_in is ready; a result passes the window,
//  product and sum registers in turn before it is on o_out.
//  A beat flagged last with t taps blocks i_in while the window stage shifts
//  its t-1 zeros in; an output stall backs up stage by stage.
//  Reset (i_rst_n low, synchronous) clears the delay line and all valids and
//  loads one tap with coef_0 = 1.
//
module full_linear_convolution (
    input  logic        i_clk,
    input  logic        i_rst_n,
    flc_in_if.sink      i_in,
    flc_cfg_if.sink     i_cfg,
    flc_out_if.source   o_out
);

    flc_pkg::t_cfg      cfg;
    flc_pkg::t_win_beat win;
    logic               win_vld;
    logic               win_rdy;

    // Configuration register file; taps come out already clamped.
    flc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Delay line plus flush sequencer: one full window per sample beat, plus the zero-fed tail after a last beat.
    flc_window u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_taps      (cfg.taps),
        .o_win       (win),
        .o_win_valid (win_vld),
        .i_win_ready (win_rdy)
    );

    // Seven parallel 16x16 products, registered, then a 34-bit exact sum.
    flc_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (win),
        .i_win_valid (win_vld),
        .o_win_ready (win_rdy),
        .i_cfg       (cfg),
        .o_out       (o_out)
    );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for full_linear_convolution. Samples are streamed in
// bursts while the result side stalls on its own pattern. A predictor kept
// here tracks the kernel and delay line and queues the expected results
// for every accepted sample beat. A short directed table comes first, then
// random phases that retune the kernel between sequences.
// ----------------------------------------------------------------------------
module tb;

    // Expected result of one output beat
    typedef struct {
        logic signed [flc_pkg::OUT_W-1:0] value;
        logic                             last;
    } t_conv_result;

    // Directed table rows: a register write or a sample beat
    typedef enum logic {ROW_WRITE, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind                        kind;
        flc_pkg::t_cfg_idx                idx;
        logic [flc_pkg::CFG_DATA_W-1:0]   wdata;
        flc_pkg::t_sample                 sample;
        logic                             last;
        bit                               known;      // typed expectation below is used
        longint                           exp_value;
        logic                             exp_last;
    } t_stim_row;

    // Result-side stall patterns
    typedef enum logic [1:0] {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PULSED} t_stall_mode;

    localparam int BEAT_TARGET = 460;
    localparam int DRAIN_LIMIT = 20000;

    logic clk;
    logic rst_n;

    flc_in_if  in_ch ();
    flc_cfg_if cfg_ch ();
    flc_out_if out_ch ();

    full_linear_convolution u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the kernel and the delay line
    // ------------------------------------------------------------------------
    logic [flc_pkg::TAPS_W-1:0] tap_count_raw;
    flc_pkg::t_coef             kernel [flc_pkg::MAX_TAPS];
    flc_pkg::t_sample           history [flc_pkg::DLY_DEPTH];   // newest first

    t_conv_result      conv_expected_q [$];
    t_stim_row         directed_plan [$];

    int                err_count;
    int                beats_sent;
    int                burst_left;

    // Typed expectation for the beat currently on the input channel
    bit                typed_on;
    longint            typed_value;
    logic              typed_last;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial begin
        #3000000;
        $display("full_linear_convolution: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        $display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint tap_sum(input flc_pkg::t_sample win [flc_pkg::MAX_TAPS],
                                       input int taps);
        longint acc;
        acc = 0;
        for (int k = 0; k < taps; k++) begin
            acc += longint'(kernel[k]) * longint'(win[k]);
        end
        return acc;
    endfunction

    function automatic void push_result(input longint acc, input logic lst);
        t_conv_result r;
        r.value = acc[flc_pkg::OUT_W-1:0];
        r.last  = lst;
        conv_expected_q.push_back(r);
    endfunction

    // Sample beat accepted: queue its result and, on last, the zero-fed tail.
    function automatic void convolve_beat(input flc_pkg::t_sample s, input logic last);
        flc_pkg::t_sample win [flc_pkg::MAX_TAPS];
        int               taps;
        taps = (tap_count_raw == '0) ? 1 : int'(tap_count_raw);
        if (taps > flc_pkg::MAX_TAPS) begin
            taps = flc_pkg::MAX_TAPS;
        end
        win[0] = s;
        for (int i = 1; i < flc_pkg::MAX_TAPS; i++) begin
            win[i] = history[i-1];
        end
        // single tap: the sample's own result closes the sequence
        push_result(tap_sum(win, taps), last && (taps == 1));
        if (last) begin
            for (int f = 1; f < taps; f++) begin
                for (int i = flc_pkg::MAX_TAPS - 1; i > 0; i--) begin
                    win[i] = win[i-1];
                end
                win[0] = '0;
                push_result(tap_sum(win, taps), f == taps - 1);
            end
            // next sequence starts from an empty delay line
            for (int i = 0; i < flc_pkg::DLY_DEPTH; i++) begin
                history[i] = '0;
            end
        end else begin
            for (int i = 0; i < flc_pkg::DLY_DEPTH; i++) begin
                history[i] = win[i];
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: all sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watch_cfg
        if (rst_n && cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
            if (flc_pkg::t_cfg_idx'(cfg_ch.index) == flc_pkg::CFG_TAP_COUNT) begin
                tap_count_raw = cfg_ch.wdata[flc_pkg::TAPS_W-1:0];
            end else begin
                kernel[int'(cfg_ch.index) - int'(flc_pkg::CFG_COEF_0)] = cfg_ch.wdata;
            end
        end
    end

    always @(posedge clk) begin : watch_in
        t_conv_result r;
        if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
            convolve_beat(in_ch.sample, in_ch.last_sample);
            // typed rows only ever cause a single result
            if (typed_on) begin
                r.value = typed_value[flc_pkg::OUT_W-1:0];
                r.last  = typed_last;
                conv_expected_q[conv_expected_q.size() - 1] = r;
            end
        end
    end

    always @(posedge clk) begin : watch_out
        t_conv_result want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (conv_expected_q.size() == 0) begin
                report("unexpected result beat, value", longint'(out_ch.out_value), 0);
            end else begin
                want = conv_expected_q.pop_front();
                if (out_ch.out_value !== want.value) begin
                    report("out_value", longint'(out_ch.out_value), longint'(want.value));
                end
                if (out_ch.out_last !== want.last) begin
                    report("out_last", longint'(out_ch.out_last), longint'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side stalls: a mode is held for a random span of cycles
    // ------------------------------------------------------------------------
    initial begin : drive_ready
        t_stall_mode mode;
        int          span;
        int          tick;
        out_ch.ready = 1'b0;
        tick = 0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge clk);
                tick++;
                case (mode)
                    READY_ALWAYS: out_ch.ready <= 1'b1;
                    READY_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    READY_RARELY: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ch.ready <= (tick % 5 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: inputs change on the falling edge
    // ------------------------------------------------------------------------
    // One sample beat. A new burst starts with a random gap (often none);
    // valid stays high between beats of a burst.
    task automatic send_beat(input flc_pkg::t_sample s, input logic last, input bit known,
                             input longint val, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= s;
        in_ch.last_sample <= last;
        typed_on    = known;
        typed_value = val;
        typed_last  = lst;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        burst_left--;
        beats_sent++;
    endtask

    task automatic write_reg(input flc_pkg::t_cfg_idx idx,
                             input logic [flc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Every beat causes a result, so an empty queue means the pipe is empty;
    // the extra wait covers the three register stages (window, product, sum) anyway.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (conv_expected_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void plan_write(input flc_pkg::t_cfg_idx idx,
                                       input logic [flc_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '{ROW_WRITE, idx, data, '0, 1'b0, 1'b0, 0, 1'b0};
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_beat(input flc_pkg::t_sample s, input logic last,
                                      input bit known, input longint val, input logic lst);
        t_stim_row row;
        row = '{ROW_BEAT, flc_pkg::CFG_TAP_COUNT, '0, s, last, known, val, lst};
        directed_plan.push_back(row);
    endfunction

    function automatic flc_pkg::t_coef pick_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return flc_pkg::t_coef'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic flc_pkg::t_sample pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return flc_pkg::t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [flc_pkg::TAPS_W-1:0] pick_taps();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return flc_pkg::TAPS_W'(1);
            2:       return flc_pkg::TAPS_W'(flc_pkg::MAX_TAPS);
            default: return flc_pkg::TAPS_W'($urandom_range(0, 7));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        logic [flc_pkg::CFG_DATA_W-1:0] tap_word;
        int                             nseq;
        int                             len;
        bit                             close;
        int                             waited;

        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.last_sample = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = flc_pkg::CFG_TAP_COUNT;
        cfg_ch.wdata      = '0;
        rst_n             = 1'b0;
        err_count   = 0;
        beats_sent  = 0;
        burst_left  = 0;
        typed_on    = 1'b0;
        typed_value = 0;
        typed_last  = 1'b0;

        // predictor at its reset values: one tap, identity kernel
        tap_count_raw = flc_pkg::RST_TAPS;
        for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
            kernel[k] = (k == 0) ? flc_pkg::RST_COEF0 : '0;
        end
        for (int i = 0; i < flc_pkg::DLY_DEPTH; i++) begin
            history[i] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed table ---
        // reset kernel passes samples through; single tap with last
        plan_beat(16'sh7fff, 1'b0, 1'b1, 32767, 1'b0);
        plan_beat(16'sh8000, 1'b0, 1'b1, -32768, 1'b0);
        plan_beat(16'sh0000, 1'b1, 1'b1, 0, 1'b1);
        // full kernel of most negative taps on most negative samples: peak sum
        plan_write(flc_pkg::CFG_TAP_COUNT, 16'(flc_pkg::MAX_TAPS));
        for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
            plan_write(flc_pkg::t_cfg_idx'(int'(flc_pkg::CFG_COEF_0) + k), 16'h8000);
        end
        plan_beat(16'sh8000, 1'b0, 1'b1, 64'sd1073741824, 1'b0);
        for (int j = 1; j < flc_pkg::MAX_TAPS; j++) begin
            plan_beat(16'sh8000, j == flc_pkg::MAX_TAPS - 1, 1'b0, 0, 1'b0);
        end
        // most positive taps: most negative sum, then tail
        for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
            plan_write(flc_pkg::t_cfg_idx'(int'(flc_pkg::CFG_COEF_0) + k), 16'h7fff);
        end
        for (int j = 0; j < flc_pkg::MAX_TAPS; j++) begin
            plan_beat(16'sh8000, j == flc_pkg::MAX_TAPS - 1, 1'b0, 0, 1'b0);
        end
        // zero tap count acts as a single tap
        plan_write(flc_pkg::CFG_TAP_COUNT, 16'h0000);
        plan_beat(16'sh0005, 1'b1, 1'b1, 163835, 1'b1);
        // tap count changed inside an open sequence
        plan_write(flc_pkg::CFG_TAP_COUNT, 16'h0002);
        plan_beat(16'sh0001, 1'b0, 1'b0, 0, 1'b0);
        plan_write(flc_pkg::CFG_TAP_COUNT, 16'h0003);
        plan_beat(16'shffff, 1'b1, 1'b0, 0, 1'b0);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(directed_plan[i].idx, directed_plan[i].wdata);
            end else begin
                send_beat(directed_plan[i].sample, directed_plan[i].last,
                          directed_plan[i].known, directed_plan[i].exp_value,
                          directed_plan[i].exp_last);
            end
        end

        // --- random phases: retune while idle, then a few sequences ---
        while (beats_sent < BEAT_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0) begin
                // upper bits of the tap word are ignored by the block
                tap_word = flc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
                tap_word[flc_pkg::TAPS_W-1:0] = pick_taps();
                write_reg(flc_pkg::CFG_TAP_COUNT, tap_word);
            end
            for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(flc_pkg::t_cfg_idx'(int'(flc_pkg::CFG_COEF_0) + k), pick_coef());
                end
            end
            nseq = $urandom_range(1, 4);
            for (int q = 0; q < nseq; q++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
                // sometimes leave the last sequence open across a retune
                close = (q != nseq - 1) || ($urandom_range(0, 4) != 0);
                for (int j = 0; j < len; j++) begin
                    send_beat(pick_sample(), close && (j == len - 1), 1'b0, 0, 1'b0);
                end
            end
        end

        // --- drain ---
        @(negedge clk);
        in_ch.valid <= 1'b0;
        waited = 0;
        while (conv_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (conv_expected_q.size() != 0) begin
            report("results never delivered, count", 0, conv_expected_q.size());
        end

        if (err_count == 0) begin
            $display("full_linear_convolution: match");
        end else begin
            $display("full_linear_convolution: mismatch");
        end
        $finish;
    end

endmodule

// ----- full_linear_convolution.f -----
+incdir+hw/rtl
hw/rtl/flc_pkg.sv
hw/rtl/flc_if.sv
hw/rtl/flc_cfg_regs.sv
hw/rtl/flc_window.sv
hw/rtl/flc_mac.sv
hw/rtl/full_linear_convolution.sv
tb/tb.sv
